>>> sv/orwm_pkg.sv
// Package for the overwrite ring window min/max unit.
// Holds command codes, sequencer states and fixed field widths.
// No dependencies.
`default_nettype none

package orwm_pkg;

  localparam int CMD_W       = 2;
  localparam int INDEX_W     = 10;
  localparam int FILL_W      = 11;
  localparam int COORD_OUT_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EVICT,
    ST_SCAN,
    ST_SCAN_END,
    ST_DONE
  } st_t;

endpackage

`default_nettype wire

>>> sv/overwrite_ring_window_minmax_unit.sv
// Overwrite ring window min/max unit: circular point store with running y extremes.
// Non-evicting append, read, clear: the execute and done states lead to the result register;
// an evicting append adds an eviction state; evicting an extreme adds a rescan of the held points.
// One item in flight; the result register lets the next item enter while a result waits.
// rst (synchronous) empties the window and invalidates the extremes; store contents stay undefined.
// Depends on orwm_pkg and orwm_store.
`default_nettype none

module overwrite_ring_window_minmax_unit
  import orwm_pkg::*;
#(
  parameter int CAPACITY    = 1024,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [CMD_W-1:0]              cmd,
  input  wire logic signed [COORD_OUT_W-1:0] point_x,
  input  wire logic signed [COORD_OUT_W-1:0] point_y,
  input  wire logic [INDEX_W-1:0]            read_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [FILL_W-1:0]                  fill_count,
  output logic                               is_full,
  output logic signed [COORD_OUT_W-1:0]      window_min_y,
  output logic signed [COORD_OUT_W-1:0]      window_max_y,
  output logic                               minmax_ok,
  output logic signed [COORD_OUT_W-1:0]      read_x,
  output logic signed [COORD_OUT_W-1:0]      read_y,
  output logic                               read_ok
);

  localparam int CW     = COORD_WIDTH;
  localparam int PTR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam int SUM_W  = ((PTR_W > INDEX_W) ? PTR_W : INDEX_W) + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic signed [CW-1:0] Y_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] Y_MIN = {1'b1, {(CW-1){1'b0}}};

  st_t state, state_next;

  cmd_t                   cmd_q;
  logic signed [CW-1:0]   x_q;
  logic signed [CW-1:0]   y_q;
  logic [INDEX_W-1:0]     idx_q;

  logic [PTR_W-1:0]       wp;
  logic [PTR_W-1:0]       op;
  logic [CNT_W-1:0]       held;
  logic signed [CW-1:0]   low;
  logic signed [CW-1:0]   high;
  logic                   ext_valid;
  logic                   evict_chk;
  logic                   rd_hit;

  logic [PTR_W-1:0]       scan_addr;
  logic [CNT_W-1:0]       scan_cnt;
  logic                   scan_first;
  logic                   scan_dv;

  logic                   mem_we;
  logic                   mem_re;
  logic [PTR_W-1:0]       mem_raddr;
  logic [2*CW-1:0]        mem_rdata;

  logic signed [CW-1:0]   rd_x;
  logic signed [CW-1:0]   rd_y;
  logic                   evicting;
  logic                   first_pt;
  logic                   hit;
  logic                   rescan_hit;
  logic                   scan_last;
  logic                   out_free;
  logic [SUM_W-1:0]       slot_sum;
  logic [SUM_W-1:0]       slot_wrap;
  logic [PTR_W-1:0]       slot;
  logic [PTR_W-1:0]       wp_inc;
  logic [PTR_W-1:0]       op_inc;
  logic [PTR_W-1:0]       scan_inc;

  assign rd_x      = mem_rdata[2*CW-1:CW];
  assign rd_y      = mem_rdata[CW-1:0];
  assign evicting  = (held == CNT_FULL);
  assign first_pt  = !ext_valid || (!evicting && (held == '0)) || (CAPACITY == 1);
  assign hit       = CMP_W'(idx_q) < CMP_W'(held);
  assign slot_sum  = SUM_W'(op) + SUM_W'(idx_q);
  assign slot_wrap = (slot_sum >= SUM_W'(CAPACITY)) ? slot_sum - SUM_W'(CAPACITY) : slot_sum;
  assign slot      = slot_wrap[PTR_W-1:0];
  assign wp_inc    = (wp == PTR_LAST) ? '0 : wp + PTR_W'(1);
  assign op_inc    = (op == PTR_LAST) ? '0 : op + PTR_W'(1);
  assign scan_inc  = (scan_addr == PTR_LAST) ? '0 : scan_addr + PTR_W'(1);
  assign rescan_hit = evict_chk && ((rd_y == low) || (rd_y == high));
  assign scan_last = (scan_cnt == held - CNT_W'(1));
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);

  orwm_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (PTR_W),
    .DATA_W (2 * CW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp),
    .wdata ({x_q, y_q}),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_q == CMD_APPEND && evicting) state_next = ST_EVICT;
        else state_next = ST_DONE;
      end
      ST_EVICT: begin
        state_next = rescan_hit ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (scan_last) state_next = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = wp;
    unique case (state)
      ST_EXEC: begin
        if (cmd_q == CMD_APPEND) begin
          mem_we    = 1'b1;
          mem_re    = evicting;
          mem_raddr = wp;
        end else if (cmd_q == CMD_READ) begin
          mem_re    = hit;
          mem_raddr = slot;
        end
      end
      ST_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = scan_addr;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cmd_q <= cmd_t'(cmd);
      x_q   <= point_x[CW-1:0];
      y_q   <= point_y[CW-1:0];
      idx_q <= read_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      op         <= '0;
      held       <= '0;
      low        <= Y_MAX;
      high       <= Y_MIN;
      ext_valid  <= 1'b0;
      evict_chk  <= 1'b0;
      rd_hit     <= 1'b0;
      scan_addr  <= '0;
      scan_cnt   <= '0;
      scan_first <= 1'b0;
      scan_dv    <= 1'b0;
    end else begin
      unique case (state)
        ST_EXEC: begin
          rd_hit    <= (cmd_q == CMD_READ) && hit;
          evict_chk <= 1'b0;
          case (cmd_q)
            CMD_APPEND: begin
              wp <= wp_inc;
              if (evicting) op <= op_inc;
              else held <= held + CNT_W'(1);
              if (first_pt) begin
                low       <= y_q;
                high      <= y_q;
                ext_valid <= 1'b1;
              end else begin
                if (y_q < low) low <= y_q;
                if (y_q > high) high <= y_q;
                evict_chk <= evicting;
              end
            end
            CMD_CLEAR: begin
              wp        <= '0;
              op        <= '0;
              held      <= '0;
              low       <= Y_MAX;
              high      <= Y_MIN;
              ext_valid <= 1'b0;
            end
            default: begin
              wp <= wp;
            end
          endcase
        end
        ST_EVICT: begin
          scan_addr  <= op;
          scan_cnt   <= '0;
          scan_first <= 1'b1;
          scan_dv    <= 1'b0;
        end
        ST_SCAN, ST_SCAN_END: begin
          if (state == ST_SCAN) begin
            scan_addr <= scan_inc;
            scan_cnt  <= scan_cnt + CNT_W'(1);
          end
          scan_dv <= (state == ST_SCAN);
          if (scan_dv) begin
            scan_first <= 1'b0;
            if (scan_first) begin
              low  <= rd_y;
              high <= rd_y;
            end else begin
              if (rd_y < low) low <= rd_y;
              if (rd_y > high) high <= rd_y;
            end
          end
        end
        default: begin
          scan_dv <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      fill_count   <= FILL_W'(held);
      is_full      <= evicting;
      window_min_y <= COORD_OUT_W'(low);
      window_max_y <= COORD_OUT_W'(high);
      minmax_ok    <= ext_valid;
      read_ok      <= rd_hit;
      read_x       <= rd_hit ? COORD_OUT_W'(rd_x) : '0;
      read_y       <= rd_hit ? COORD_OUT_W'(rd_y) : '0;
    end
  end

endmodule

`default_nettype wire

>>> sv/orwm_store.sv
// Point store: single synchronous memory, one write and one read port.
// Read data is registered and returns the old contents on a same-address write.
// No package dependencies.
`default_nettype none

module orwm_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 64
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/orwm_checker.sv
// Port-level checker for the overwrite ring window min/max unit, bound to the top level.
// Depends on orwm_pkg for field widths.
`default_nettype none

module orwm_checker
  import orwm_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [FILL_W-1:0]             fill_count,
  input wire logic signed [COORD_OUT_W-1:0] window_min_y,
  input wire logic signed [COORD_OUT_W-1:0] window_max_y,
  input wire logic                          minmax_ok,
  input wire logic signed [COORD_OUT_W-1:0] read_x,
  input wire logic signed [COORD_OUT_W-1:0] read_y,
  input wire logic                          read_ok
);

  localparam logic signed [COORD_OUT_W-1:0] Y_MAX =
    COORD_OUT_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [COORD_OUT_W-1:0] Y_MIN = -Y_MAX - COORD_OUT_W'(1);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(fill_count) && $stable(read_x))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken before the first finished");

  a_empty_extremes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !minmax_ok |-> window_min_y == Y_MAX && window_max_y == Y_MIN)
    else $error("invalid extremes not at reset values");

  a_valid_extremes: assert property (@(posedge clk) disable iff (rst)
    out_valid && minmax_ok |-> window_min_y <= window_max_y && fill_count != '0)
    else $error("extremes inconsistent with held points");

  a_read_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_ok |-> read_x == '0 && read_y == '0)
    else $error("read data not zero on miss");

endmodule

bind overwrite_ring_window_minmax_unit orwm_checker #(.COORD_WIDTH(COORD_WIDTH)) u_orwm_checker (.*);

`default_nettype wire
